// File: rtl/pet_pkg.sv
`default_nettype none

package pet_pkg;

   // Unit table geometry
   localparam int NUM_UNITS   = 16;
   localparam int UNIT_W      = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
   localparam int UNIT_PORT_W = 4;

   // Field widths
   localparam int TIME_W    = 32;
   localparam int PERIOD_W  = 16;
   localparam int COUNT_W   = 13;
   localparam int CSR_IDX_W = 2;

   // Opcodes of a request word
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZON    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_EVENTS = 2'd2;

   // Register reset values
   localparam logic [TIME_W-1:0]   HORIZON_RST    = '0;
   localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd1000;
   localparam logic [COUNT_W-1:0]  MAX_EVENTS_RST = 13'd4096;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_WB
   } state_type;

   // One table entry handed to the minimum tracker
   typedef struct packed {
      logic              clear;
      logic              valid;
      logic              eligible;
      logic [UNIT_W-1:0] unit;
      logic [TIME_W-1:0] time_ms;
   } scan_sample_type;

   // Running minimum over the entries seen so far
   typedef struct packed {
      logic              found;
      logic [UNIT_W-1:0] unit;
      logic [TIME_W-1:0] time_ms;
   } scan_best_type;

endpackage

`default_nettype wire

// File: rtl/pet_min_track.sv
`default_nettype none

module pet_min_track
   import pet_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire scan_sample_type sample,
   output scan_best_type        best
);

   logic              found_ff, found_in;
   logic [UNIT_W-1:0] unit_ff, unit_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic              take;

   // Strict compare: entries arrive in ascending unit order, so ties keep the lowest unit
   assign take = sample.valid && sample.eligible && (!found_ff || (sample.time_ms < time_ff));

   always_comb begin
      found_in = found_ff;
      unit_in  = unit_ff;
      time_in  = time_ff;
      if (sample.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         unit_in  = sample.unit;
         time_in  = sample.time_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
      time_ff <= time_in;
   end

   assign best.found   = found_ff;
   assign best.unit    = unit_ff;
   assign best.time_ms = time_ff;

endmodule

`default_nettype wire

// File: rtl/periodic_event_time_merger.sv
`default_nettype none

// Channel    Handshake                 Payload
// request    start / busy              req_opcode, req_unit_index, req_unit_used,
//                                      req_first_time_ms
// response   rsp_valid (strobe)        rsp_event_valid, rsp_event_time_ms,
//                                      rsp_event_unit, rsp_done_res
// registers  csr_valid / csr_ready     csr_index, csr_wdata
//
// A load, or a pop that meets the event cap, answers in the cycle after it is
// accepted. Any other pop scans the time table through its single read port,
// one entry a cycle, passes the last-read state, then writes back the winner;
// its response is registered from the write-back state. Reset is synchronous
// and clears the active flags, the event count and the registers; the time
// table needs none. Responses are strobed for one cycle and are never held off.

module periodic_event_time_merger
   import pet_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_opcode,
   input  wire logic [UNIT_PORT_W-1:0] req_unit_index,
   input  wire logic                   req_unit_used,
   input  wire logic [TIME_W-1:0]      req_first_time_ms,

   output logic                        rsp_valid,
   output logic                        rsp_event_valid,
   output logic [TIME_W-1:0]           rsp_event_time_ms,
   output logic [UNIT_PORT_W-1:0]      rsp_event_unit,
   output logic                        rsp_done_res,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [TIME_W-1:0]      csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [TIME_W-1:0]   horizon_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [COUNT_W-1:0]  max_events_ff;

   // Writes are to arrive only while idle (not enforced here); the port is always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         horizon_ff    <= HORIZON_RST;
         period_ff     <= PERIOD_RST;
         max_events_ff <= MAX_EVENTS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HORIZON:    horizon_ff    <= csr_wdata;
            CSR_PERIOD:     period_ff     <= csr_wdata[PERIOD_W-1:0];
            CSR_MAX_EVENTS: max_events_ff <= csr_wdata[COUNT_W-1:0];
            default: begin
               // unknown index: drop the word
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic               accept;
   logic               load_fire;
   logic               pop_fire;
   logic               cap_hit;
   logic               load_in_range;
   logic [UNIT_W-1:0]  load_idx;
   logic [COUNT_W-1:0] emitted_ff, emitted_in;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign load_fire = accept && (req_opcode == OP_LOAD);
   assign pop_fire  = accept && (req_opcode == OP_POP);
   assign cap_hit   = (emitted_ff >= max_events_ff);

   assign load_in_range = (32'(req_unit_index) < 32'(NUM_UNITS));
   assign load_idx      = UNIT_W'(req_unit_index);

   // ------------------------------------------------------------------
   // Sequencer: scan every entry, then write back the winner
   // ------------------------------------------------------------------
   logic              scan_clear;
   logic              rd_en;
   logic              wb_en;
   logic [UNIT_W-1:0] rd_idx_ff, rd_idx_in;
   logic              rd_last;

   assign rd_last = (rd_idx_ff == UNIT_W'(NUM_UNITS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_fire && !cap_hit) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_last) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: state_in = ST_WB;
         ST_WB:   state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      scan_clear = 1'b0;
      rd_en      = 1'b0;
      wb_en      = 1'b0;
      rd_idx_in  = rd_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            scan_clear = pop_fire && !cap_hit;
            rd_idx_in  = '0;
         end
         ST_SCAN: begin
            rd_en     = 1'b1;
            rd_idx_in = rd_idx_ff + UNIT_W'(1);
         end
         ST_LAST: begin
            rd_idx_in = '0;
         end
         ST_WB: begin
            wb_en = 1'b1;
         end
         default: begin
            rd_idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_idx_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   // ------------------------------------------------------------------
   // Time table: one write port, one registered read port
   // ------------------------------------------------------------------
   logic [TIME_W-1:0] time_mem [NUM_UNITS];
   logic [TIME_W-1:0] mem_q_ff;
   logic              mem_we;
   logic [UNIT_W-1:0] mem_waddr;
   logic [TIME_W-1:0] mem_wdata;
   logic              rd_vld_ff;
   logic [UNIT_W-1:0] rd_unit_ff;

   scan_best_type         best;
   logic [TIME_W:0]       adv_sum;
   logic                  adv_drop;

   // Advance the winner by one period; drop it on overflow or past the horizon
   assign adv_sum  = {1'b0, best.time_ms} + (TIME_W + 1)'(period_ff);
   assign adv_drop = adv_sum[TIME_W] || (adv_sum[TIME_W-1:0] > horizon_ff);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = load_idx;
      mem_wdata = req_first_time_ms;
      if (load_fire && load_in_range) begin
         mem_we = 1'b1;
      end else if (wb_en && best.found) begin
         mem_we    = 1'b1;
         mem_waddr = best.unit;
         mem_wdata = adv_sum[TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         time_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         mem_q_ff <= time_mem[rd_idx_ff];
      end
   end

   // Track which entry the read data belongs to
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_unit_ff <= rd_idx_ff;
   end

   // ------------------------------------------------------------------
   // Active flags and minimum search
   // ------------------------------------------------------------------
   logic [NUM_UNITS-1:0] active_ff;
   logic                 smp_active;
   logic                 smp_late;
   scan_sample_type      sample;

   assign smp_active = active_ff[rd_unit_ff];
   assign smp_late   = (mem_q_ff > horizon_ff);

   assign sample.clear    = scan_clear;
   assign sample.valid    = rd_vld_ff;
   assign sample.eligible = smp_active && !smp_late;
   assign sample.unit     = rd_unit_ff;
   assign sample.time_ms  = mem_q_ff;

   pet_min_track u_min_track (
      .clock  (clock),
      .reset  (reset),
      .sample (sample),
      .best   (best)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         if (load_fire && load_in_range) begin
            active_ff[load_idx] <= req_unit_used;
         end
         // Retire a unit once the scan sees it beyond the horizon
         if (rd_vld_ff && smp_active && smp_late) begin
            active_ff[rd_unit_ff] <= 1'b0;
         end
         if (wb_en && best.found && adv_drop) begin
            active_ff[best.unit] <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Event count
   // ------------------------------------------------------------------
   assign emitted_in = (wb_en && best.found) ? emitted_ff + COUNT_W'(1) : emitted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         emitted_ff <= '0;
      end else begin
         emitted_ff <= emitted_in;
      end
   end

   // ------------------------------------------------------------------
   // Response word
   // ------------------------------------------------------------------
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ev_ff, rsp_ev_in;
   logic [TIME_W-1:0]      rsp_time_ff, rsp_time_in;
   logic [UNIT_PORT_W-1:0] rsp_unit_ff, rsp_unit_in;
   logic                   rsp_done_ff, rsp_done_in;

   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_ev_in    = 1'b0;
      rsp_time_in  = '0;
      rsp_unit_in  = '0;
      rsp_done_in  = 1'b0;
      if (load_fire) begin
         rsp_valid_in = 1'b1;
      end else if (pop_fire && cap_hit) begin
         rsp_valid_in = 1'b1;
         rsp_done_in  = 1'b1;
      end else if (wb_en) begin
         rsp_valid_in = 1'b1;
         if (best.found) begin
            rsp_ev_in   = 1'b1;
            rsp_time_in = best.time_ms;
            rsp_unit_in = UNIT_PORT_W'(best.unit);
         end else begin
            rsp_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ev_ff   <= rsp_ev_in;
      rsp_time_ff <= rsp_time_in;
      rsp_unit_ff <= rsp_unit_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_valid   = rsp_ev_ff;
   assign rsp_event_time_ms = rsp_time_ff;
   assign rsp_event_unit    = rsp_unit_ff;
   assign rsp_done_res      = rsp_done_ff;

endmodule

`default_nettype wire

// File: tb/sv/periodic_event_time_merger_tb.sv
module periodic_event_time_merger_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pet_pkg::*;

   // Run length and limits
   localparam int ITEM_TARGET    = 1200;
   localparam int IDLE_LIMIT     = 2000;   // cycles with no handshake and no result
   localparam int QUIET_CYCLES   = 3 * NUM_UNITS + 10;
   localparam int MAX_REPORTS    = 10;
   localparam int MAX_BURST      = 24;
   localparam int MAX_GAP        = 30;

   // One response word as the merger presents it
   typedef struct packed {
      logic                   event_valid;
      logic [TIME_W-1:0]      event_time_ms;
      logic [UNIT_PORT_W-1:0] event_unit;
      logic                   done_res;
   } merge_event_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_opcode;
   logic [UNIT_PORT_W-1:0] req_unit_index;
   logic                   req_unit_used;
   logic [TIME_W-1:0]      req_first_time_ms;
   logic                   rsp_valid;
   logic                   rsp_event_valid;
   logic [TIME_W-1:0]      rsp_event_time_ms;
   logic [UNIT_PORT_W-1:0] rsp_event_unit;
   logic                   rsp_done_res;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [TIME_W-1:0]      csr_wdata;

   // Shadow of the unit table and of the registers, advanced at each accepted word
   logic [TIME_W-1:0]   sched_time [NUM_UNITS];
   logic                sched_active [NUM_UNITS];
   logic [COUNT_W-1:0]  events_emitted;
   logic [TIME_W-1:0]   cfg_horizon;
   logic [PERIOD_W-1:0] cfg_period;
   logic [COUNT_W-1:0]  cfg_max_events;

   // Responses still owed by the merger, oldest first
   merge_event_type pending_events[$];
   merge_event_type last_event;

   int error_count     = 0;
   int items_sent      = 0;
   int loads_sent      = 0;
   int pops_sent       = 0;
   int register_writes = 0;
   int events_seen     = 0;
   int dones_seen      = 0;
   int burst_left      = 0;

   periodic_event_time_merger i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_unit_index    (req_unit_index),
      .req_unit_used     (req_unit_used),
      .req_first_time_ms (req_first_time_ms),
      .rsp_valid         (rsp_valid),
      .rsp_event_valid   (rsp_event_valid),
      .rsp_event_time_ms (rsp_event_time_ms),
      .rsp_event_unit    (rsp_event_unit),
      .rsp_done_res      (rsp_done_res),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Work out the response to one request word and advance the shadow table.
   // A pop below the cap scans every active unit: drop those past the horizon, keep the
   // smallest time with the lowest index winning a tie, then step the winner
   // on by one period, dropping it if the step wraps 32 bits or passes the horizon.
   function automatic merge_event_type next_merged_event(input logic op,
                                                      input logic [UNIT_PORT_W-1:0] idx,
                                                      input logic used,
                                                      input logic [TIME_W-1:0] first_ms);
      merge_event_type   ev;
      int                best;
      int                u;
      logic [TIME_W-1:0] best_time;
      logic [TIME_W:0]   advanced;
      ev        = '0;
      best      = -1;
      best_time = '0;
      if (op == OP_LOAD) begin
         if (idx < NUM_UNITS) begin
            sched_time[idx]   = first_ms;
            sched_active[idx] = used;
         end
         return ev;
      end
      // Cap reached: answer done without touching the table
      if (events_emitted >= cfg_max_events) begin
         ev.done_res = 1'b1;
         return ev;
      end
      for (u = 0; u < NUM_UNITS; u++) begin
         if (!sched_active[u])
            continue;
         if (sched_time[u] > cfg_horizon) begin
            sched_active[u] = 1'b0;
            continue;
         end
         if (best < 0 || sched_time[u] < best_time) begin
            best      = u;
            best_time = sched_time[u];
         end
      end
      if (best < 0) begin
         ev.done_res = 1'b1;
         return ev;
      end
      ev.event_valid   = 1'b1;
      ev.event_time_ms = best_time;
      ev.event_unit    = UNIT_PORT_W'(best);
      events_emitted   = events_emitted + 1'b1;
      advanced         = {1'b0, best_time} + (TIME_W + 1)'(cfg_period);
      if (advanced[TIME_W] || advanced[TIME_W-1:0] > cfg_horizon)
         sched_active[best] = 1'b0;
      sched_time[best] = advanced[TIME_W-1:0];
      return ev;
   endfunction

   // Hand one request word to the merger. Bursts of random length are
   // separated by random gaps; here start is only lowered when a gap opens, so
   // back-to-back words keep it high across the acceptance edge.
   task automatic send_word(input logic op, input logic [UNIT_PORT_W-1:0] idx,
                            input logic used, input logic [TIME_W-1:0] first_ms);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, MAX_BURST);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_opcode        <= op;
      req_unit_index    <= idx;
      req_unit_used     <= used;
      req_first_time_ms <= first_ms;
      start             <= 1'b1;
      // Hold the word until an edge sees busy low
      do @(posedge clock); while (busy);
      last_event = next_merged_event(op, idx, used, first_ms);
      pending_events.push_back(last_event);
      items_sent++;
      if (op == OP_LOAD)
         loads_sent++;
      else
         pops_sent++;
   endtask

   // Stop sending and hold until every owed response has come back
   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   // One register write; valid drops for a cycle afterwards so that two
   // writes never share an edge
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [TIME_W-1:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_HORIZON:    cfg_horizon    = value;
         CSR_PERIOD:     cfg_period     = value[PERIOD_W-1:0];
         CSR_MAX_EVENTS: cfg_max_events = value[COUNT_W-1:0];
         default: ;
      endcase
      register_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drain the merger, then set all three registers
   task automatic program_schedule(input logic [TIME_W-1:0] horizon,
                                   input logic [TIME_W-1:0] period,
                                   input logic [TIME_W-1:0] cap);
      wait_for_drain();
      write_register(CSR_HORIZON, horizon);
      write_register(CSR_PERIOD, period);
      write_register(CSR_MAX_EVENTS, cap);
   endtask

   // Extreme times and indices; the top unit at the last representable
   // millisecond wraps on its advance and must drop out
   task automatic test_load_extremes();
      program_schedule(32'hFFFF_FFFF, 32'h0000_FFFF, 32'(MAX_EVENTS_RST));
      send_word(OP_LOAD, 4'd0, 1'b1, 32'h0000_0000);
      send_word(OP_LOAD, 4'd15, 1'b1, 32'hFFFF_FFFF);
      send_word(OP_LOAD, 4'd7, 1'b0, 32'hA5A5_5A5A);
      send_word(OP_POP, 4'd0, 1'b0, 32'h0);
      send_word(OP_POP, 4'd0, 1'b0, 32'h0);
      // Retire unit 0 so that unit 15 comes up next
      send_word(OP_LOAD, 4'd0, 1'b0, 32'h5A5A_A5A5);
      send_word(OP_POP, 4'd0, 1'b0, 32'h0);
      send_word(OP_POP, 4'd0, 1'b0, 32'h0);
   endtask

   // Equal times: the lowest unit index goes first
   task automatic test_tie_break();
      program_schedule(32'd1000, 32'd100, 32'(MAX_EVENTS_RST));
      send_word(OP_LOAD, 4'd9, 1'b1, 32'd500);
      send_word(OP_LOAD, 4'd3, 1'b1, 32'd500);
      send_word(OP_LOAD, 4'd12, 1'b1, 32'd400);
      repeat (4) send_word(OP_POP, 4'd0, 1'b0, 32'h0);
   endtask

   // Units past the horizon drop out on the scan and stay out once it is raised
   task automatic test_beyond_horizon();
      program_schedule(32'd100, 32'd100, 32'(MAX_EVENTS_RST));
      send_word(OP_LOAD, 4'd5, 1'b1, 32'd2000);
      send_word(OP_POP, 4'd0, 1'b0, 32'h0);
      wait_for_drain();
      write_register(CSR_HORIZON, 32'd5000);
      send_word(OP_POP, 4'd0, 1'b0, 32'h0);
   endtask

   // Zero period repeats one event until the cap stops it; loads still answer
   task automatic test_period_zero_and_cap();
      program_schedule(32'hFFFF_FFFF, 32'd0, 32'(events_emitted) + 32'd3);
      send_word(OP_LOAD, 4'd4, 1'b1, 32'd77);
      repeat (4) send_word(OP_POP, 4'd0, 1'b0, 32'h0);
      send_word(OP_LOAD, 4'd8, 1'b1, 32'd10);
      send_word(OP_POP, 4'd0, 1'b0, 32'h0);
   endtask

   // Random schedules: set registers, load a set of units whose first times
   // mostly sit within 3 * period + 3 above a base time, then pop until done comes
   // twice or the pop budget runs out, with stray loads and full-drain pauses mixed in
   task automatic test_random_schedules();
      longint base;
      longint hz;
      longint t;
      int     period;
      int     cap;
      int     n_loads;
      int     max_pops;
      int     pops;
      int     dones;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0:       period = 0;
            1:       period = 65535;
            default: period = $urandom_range(1, 3000);
         endcase
         base = ($urandom_range(0, 3) == 0) ? longint'($urandom)
                                            : longint'($urandom_range(0, 50000));
         case ($urandom_range(0, 9))
            0:       hz = 0;
            1:       hz = 64'hFFFF_FFFF;
            default: hz = base + longint'(period) * longint'($urandom_range(0, 12));
         endcase
         if (hz > 64'hFFFF_FFFF)
            hz = 64'hFFFF_FFFF;
         case ($urandom_range(0, 5))
            0:       cap = int'(events_emitted) + $urandom_range(0, 8);
            1:       cap = $urandom_range(0, 4096);
            default: cap = int'(MAX_EVENTS_RST);
         endcase
         program_schedule(hz[TIME_W-1:0], 32'(period), 32'(cap));

         n_loads = $urandom_range(1, NUM_UNITS);
         repeat (n_loads) begin
            case ($urandom_range(0, 7))
               0:       t = longint'($urandom);
               1:       t = hz + longint'($urandom_range(1, 1000));
               default: t = base + longint'($urandom_range(0, 3 * period + 3));
            endcase
            if (t > 64'hFFFF_FFFF)
               t = 64'hFFFF_FFFF;
            send_word(OP_LOAD, UNIT_PORT_W'($urandom_range(0, NUM_UNITS - 1)),
                      ($urandom_range(0, 4) != 0), t[TIME_W-1:0]);
         end

         max_pops = $urandom_range(4, 60);
         pops     = 0;
         dones    = 0;
         while (pops < max_pops && dones < 2) begin
            if ($urandom_range(0, 9) == 0) begin
               // Stray load with arbitrary content
               send_word(OP_LOAD, UNIT_PORT_W'($urandom_range(0, NUM_UNITS - 1)),
                         1'($urandom_range(0, 1)), $urandom);
            end else begin
               send_word(OP_POP, UNIT_PORT_W'($urandom_range(0, NUM_UNITS - 1)),
                         1'($urandom_range(0, 1)), $urandom);
               pops++;
               if (last_event.done_res)
                  dones++;
            end
            if ($urandom_range(0, 29) == 0)
               wait_for_drain();
         end
      end
   endtask

   // Compare every strobed response with the oldest owed word
   always @(posedge clock) begin
      merge_event_type want;
      if (!reset && rsp_valid) begin
         if (pending_events.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: response with none owed: valid=%0b time=%0d unit=%0d done=%0b",
                        $time, rsp_event_valid, rsp_event_time_ms, rsp_event_unit,
                        rsp_done_res);
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_valid !== want.event_valid ||
                rsp_event_time_ms !== want.event_time_ms ||
                rsp_event_unit !== want.event_unit ||
                rsp_done_res !== want.done_res) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"%0t: mismatch: expected valid=%0b time=%0d unit=%0d done=%0b,",
                            " got valid=%0b time=%0d unit=%0d done=%0b"},
                           $time, want.event_valid, want.event_time_ms, want.event_unit,
                           want.done_res, rsp_event_valid, rsp_event_time_ms,
                           rsp_event_unit, rsp_done_res);
            end
            if (want.event_valid)
               events_seen++;
            if (want.done_res)
               dones_seen++;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout after %0d idle cycles, %0d responses still owed",
               IDLE_LIMIT, pending_events.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      // Drive every input to a known value and hold reset asserted
      reset             <= 1'b1;
      start             <= 1'b0;
      req_opcode        <= OP_LOAD;
      req_unit_index    <= '0;
      req_unit_used     <= 1'b0;
      req_first_time_ms <= '0;
      csr_valid         <= 1'b0;
      csr_index         <= CSR_HORIZON;
      csr_wdata         <= '0;
      // Shadow state matches the block after reset
      cfg_horizon    = HORIZON_RST;
      cfg_period     = PERIOD_RST;
      cfg_max_events = MAX_EVENTS_RST;
      events_emitted = '0;
      for (int u = 0; u < NUM_UNITS; u++) begin
         sched_active[u] = 1'b0;
         sched_time[u]   = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_load_extremes();
      test_tie_break();
      test_beyond_horizon();
      test_period_zero_and_cap();
      test_random_schedules();

      // Let the last responses arrive, then watch for stray strobes
      wait_for_drain();
      repeat (QUIET_CYCLES) @(posedge clock);
      error_count += pending_events.size();

      $display("Run covered %0d loads and %0d pops across %0d register writes,",
               loads_sent, pops_sent, register_writes);
      $display("answered with %0d events and %0d done words; %0d errors.",
               events_seen, dones_seen, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
